// File: hdl/skt_pkg.sv
package skt_pkg;

  // Default table shape.
  localparam int unsigned DefDepth    = 64;
  localparam int unsigned DefKeyBytes = 8;

  // Fixed field widths at the block boundary.
  localparam int unsigned KeyW  = 64;
  localparam int unsigned PayW  = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned StatW = 2;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Kind of result the controller asks the datapath to record.
  typedef enum logic [1:0] {
    RES_FOUND,
    RES_MISS,
    RES_FULL,
    RES_INS
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the request and open the search window
    logic rd_mid;      // read the entry at the window midpoint
    logic step;        // narrow the window from the compare result
    logic shift_init;  // start moving entries up from the top
    logic shift_step;  // one step of the entry move
    logic put;         // write the new entry and bump the count
    logic set_res;     // record the result below
    res_e res_kind;
    logic out_load;    // move the recorded result to the output register
  } skt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ins;      // latched request is an insert
    logic full;        // table holds its maximum number of entries
    logic range_empty; // search window is empty
    logic key_eq;      // entry just read matches the request key
    logic shift_done;  // all entries at and above the slot have moved
  } skt_sts_t;

endpackage

// File: hdl/sorted_key_table_core.sv
// Channel  Handshake                Payload
// -------  -----------------------  ----------------------------------------
// input    in_valid_i/in_stall_o    req_type_i, key_i, payload_i
// output   out_valid_o/out_stall_i  status_o, position_o, entry_payload_o
//
// One request at a time. A lookup makes at most log2(DEPTH)+1 search probes. An insert
// searches the same way, then moves every entry at and above its slot up by one place
// through the single read and write port, and then writes the new entry at the slot.
// Reset empties the table; no clearing pass is needed. A waiting result does not block
// the next request; a stalled output holds the response state only behind a second one.
module sorted_key_table_core #(
  parameter int unsigned DEPTH     = skt_pkg::DefDepth,
  parameter int unsigned KEY_BYTES = skt_pkg::DefKeyBytes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [skt_pkg::KeyW-1:0]  key_i,
  input  logic [skt_pkg::PayW-1:0]  payload_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [skt_pkg::StatW-1:0] status_o,
  output logic [skt_pkg::PosW-1:0]  position_o,
  output logic [skt_pkg::PayW-1:0]  entry_payload_o
);

  import skt_pkg::*;

  skt_cmd_t cmd;
  skt_sts_t sts;

  // Request sequencing.
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Entry memories, search window and result registers.
  skt_dp #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .status_o        (status_o),
    .position_o      (position_o),
    .entry_payload_o (entry_payload_o)
  );

endmodule

// File: hdl/skt_ram.sv
module skt_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/skt_dp.sv
module skt_dp #(
  parameter int unsigned DEPTH     = skt_pkg::DefDepth,
  parameter int unsigned KEY_BYTES = skt_pkg::DefKeyBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skt_pkg::skt_cmd_t           cmd_i,
  output skt_pkg::skt_sts_t           sts_o,
  input  logic                        req_type_i,
  input  logic [skt_pkg::KeyW-1:0]    key_i,
  input  logic [skt_pkg::PayW-1:0]    payload_i,
  output logic [skt_pkg::StatW-1:0]   status_o,
  output logic [skt_pkg::PosW-1:0]    position_o,
  output logic [skt_pkg::PayW-1:0]    entry_payload_o
);

  import skt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned KW = 8 * KEY_BYTES;

  // Request registers.
  logic          req_ins_q;
  logic [KW-1:0] key_q;
  logic [PayW-1:0] pay_q;

  // Table fill and search window (half-open: lo up to but not including hi).
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [AW-1:0] mid_q;

  // Entry move state.
  logic [CW-1:0] nx_q;
  logic [AW-1:0] wa_q;
  logic          wr_pend_q;

  // Result and output registers.
  status_e         res_st_q;
  logic [AW-1:0]   res_pos_q;
  logic [PayW-1:0] res_pay_q;
  logic [StatW-1:0] out_st_q;
  logic [PosW-1:0]  out_pos_q;
  logic [PayW-1:0]  out_pay_q;

  // Memory ports.
  logic          ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [KW-1:0] ram_wkey, rd_key;
  logic [PayW-1:0] ram_wpay, rd_pay;

  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_w;
  logic          key_lt;
  logic          sh_more;

  // Midpoint of the inclusive range lo..hi-1, rounded down.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign mid_w   = mid_sum[AW:1];

  assign key_lt  = rd_key < key_q;
  assign sh_more = nx_q > lo_q;

  // Status back to the controller.
  assign sts_o.is_ins      = req_ins_q;
  assign sts_o.full        = cnt_q == CW'(DEPTH);
  assign sts_o.range_empty = lo_q >= hi_q;
  assign sts_o.key_eq      = rd_key == key_q;
  assign sts_o.shift_done  = !wr_pend_q && (nx_q == lo_q);

  // Read port: search probes, or the entry below the move pointer.
  assign ram_re    = cmd_i.rd_mid || (cmd_i.shift_step && sh_more);
  assign ram_raddr = cmd_i.rd_mid ? mid_w : AW'(nx_q - CW'(1));

  // Write port: moved entries, or the new entry at the insertion slot.
  assign ram_we    = cmd_i.put || (cmd_i.shift_step && wr_pend_q);
  assign ram_waddr = cmd_i.put ? lo_q[AW-1:0] : wa_q;
  assign ram_wkey  = cmd_i.put ? key_q : rd_key;
  assign ram_wpay  = cmd_i.put ? pay_q : rd_pay;

  skt_ram #(.W(KW), .D(DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wkey),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_key)
  );

  skt_ram #(.W(PayW), .D(DEPTH)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wpay),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_pay)
  );

  // Window update: a smaller stored key moves lo past the probe, otherwise hi drops to it.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = cnt_q;
    end else if (cmd_i.step) begin
      if (key_lt) begin
        lo_d = CW'(mid_q) + CW'(1);
      end else begin
        hi_d = CW'(mid_q);
      end
    end
  end

  // Control state: entry count and the pending move write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      if (cmd_i.put) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.shift_init) begin
        wr_pend_q <= 1'b0;
      end else if (cmd_i.shift_step) begin
        wr_pend_q <= sh_more;
      end
    end
  end

  // Request, window and move pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_ins_q <= req_type_i;
      key_q     <= key_i[KeyW-1 -: KW];
      pay_q     <= payload_i;
    end
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.rd_mid) begin
      mid_q <= mid_w;
    end
    if (cmd_i.shift_init) begin
      nx_q <= cnt_q;
    end else if (cmd_i.shift_step && sh_more) begin
      nx_q <= nx_q - CW'(1);
      wa_q <= nx_q[AW-1:0];
    end
  end

  // Result capture and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      unique case (cmd_i.res_kind)
        RES_FOUND: begin
          res_st_q  <= ST_OK;
          res_pos_q <= mid_q;
          res_pay_q <= rd_pay;
        end
        RES_INS: begin
          res_st_q  <= ST_OK;
          res_pos_q <= lo_q[AW-1:0];
          res_pay_q <= '0;
        end
        RES_FULL: begin
          res_st_q  <= ST_FULL;
          res_pos_q <= '0;
          res_pay_q <= '0;
        end
        default: begin
          res_st_q  <= ST_MISS;
          res_pos_q <= '0;
          res_pay_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_st_q  <= res_st_q;
      out_pos_q <= PosW'(res_pos_q);
      out_pay_q <= res_pay_q;
    end
  end

  assign status_o        = out_st_q;
  assign position_o      = out_pos_q;
  assign entry_payload_o = out_pay_q;

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // Writing the new entry grows the table by exactly one.
  a_put_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("entry count did not step on insert");

  // A moved entry always lands above the insertion slot.
  a_move_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_step && wr_pend_q) |-> CW'(wa_q) > lo_q)
    else $error("entry move overwrote the insertion slot or below");

endmodule

// File: hdl/skt_ctrl.sv
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skt_pkg::skt_cmd_t cmd_o,
  input  skt_pkg::skt_sts_t sts_i
);

  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_PUT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Sequencing: search probes, then for an insert the entry move and the write.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.is_ins && sts_i.full) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = RES_FULL;
          state_d        = S_RESP;
        end else if (sts_i.range_empty) begin
          if (sts_i.is_ins) begin
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end else begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_kind = RES_MISS;
            state_d        = S_RESP;
          end
        end else begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        if (!sts_i.is_ins && sts_i.key_eq) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = RES_FOUND;
          state_d        = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_PROBE;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = S_PUT;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_PUT: begin
        cmd_o.put      = 1'b1;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_kind = RES_INS;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= cmd_o.out_load || (out_valid_q && out_stall_i);
    end
  end

  // A new request always closes the input until its result is handed over.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input open right after a request");

  // A result only appears after the response state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response state");

endmodule
